[hw/rtl/rfp_pkg.sv]
// Shared constants and codes for the relocation field patcher.
package rfp_pkg;

  // Field widths
  localparam int unsigned OpW      = 5;
  localparam int unsigned ValW     = 64;
  localparam int unsigned WordW    = 32;
  localparam int unsigned StW      = 3;
  localparam int unsigned CfgW     = 20;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  // Relocation kinds
  localparam logic [OpW-1:0] OP_ABS32         = 5'd0;
  localparam logic [OpW-1:0] OP_COG_PC20      = 5'd1;
  localparam logic [OpW-1:0] OP_COG_PC9       = 5'd2;
  localparam logic [OpW-1:0] OP_COG_DATA9     = 5'd3;
  localparam logic [OpW-1:0] OP_COG_PCREL9    = 5'd4;
  localparam logic [OpW-1:0] OP_LUT_PC20      = 5'd5;
  localparam logic [OpW-1:0] OP_LUT_PC9       = 5'd6;
  localparam logic [OpW-1:0] OP_LUT_DATA9     = 5'd7;
  localparam logic [OpW-1:0] OP_LUT_PCREL9    = 5'd8;
  localparam logic [OpW-1:0] OP_HUB_PC20      = 5'd9;
  localparam logic [OpW-1:0] OP_HUB_PCREL20   = 5'd10;
  localparam logic [OpW-1:0] OP_HUB_PCAUG32   = 5'd11;
  localparam logic [OpW-1:0] OP_HUB_DATAAUG32 = 5'd12;
  localparam logic [OpW-1:0] OP_COG_PCAUG32   = 5'd13;
  localparam logic [OpW-1:0] OP_LUT_PCAUG32   = 5'd14;
  localparam logic [OpW-1:0] OP_OBSOLETE      = 5'd15;

  // Status codes
  localparam logic [StW-1:0] ST_OK    = 3'd0;
  localparam logic [StW-1:0] ST_COG   = 3'd1;
  localparam logic [StW-1:0] ST_LUTLO = 3'd2;
  localparam logic [StW-1:0] ST_LUTHI = 3'd3;
  localparam logic [StW-1:0] ST_RANGE = 3'd4;
  localparam logic [StW-1:0] ST_OBS   = 3'd5;
  localparam logic [StW-1:0] ST_UNK   = 3'd6;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_COG_ABI_MAX = 2'd0;
  localparam logic [1:0] REG_LUT_BASE    = 2'd1;
  localparam logic [1:0] REG_LUT_LIMIT   = 2'd2;

  // Register reset values
  localparam logic [CfgW-1:0] COG_ABI_MAX_RST = 20'd462;
  localparam logic [CfgW-1:0] LUT_BASE_RST    = 20'd512;
  localparam logic [CfgW-1:0] LUT_LIMIT_RST   = 20'd1023;

  // Field masks
  localparam logic [WordW-1:0] MASK9  = 32'h0000_01ff;
  localparam logic [WordW-1:0] MASK20 = 32'h000f_ffff;
  localparam logic [WordW-1:0] MASK23 = 32'h007f_ffff;

  // Signed 9-bit field limit for negative quotients
  localparam logic [8:0] NEG9_MAX = 9'd256;

endpackage

[hw/rtl/relocation_field_patcher.sv]
// Relocation field patcher: three-stage pipeline that rewrites one relocation site per beat.
//
//   channel | ports                | beat contents
//   --------+----------------------+-------------------------------------------------
//   in      | in_tvalid/tready     | tuser: operation; tdata: value, inst, prefix
//   out     | out_tvalid/tready    | tuser: prefix_written, status; tdata: inst, prefix
//   cfg     | cfg_psel/penable/... | cog_abi_max @0x0, lut_base @0x4, lut_limit @0x8
//
// One beat per cycle sustained while out_tready is high; each beat passes the stages in turn
// (wide subtract/negate, bound checks and field select, word merge into the output register).
// Valid bits travel with each stage; a stage loads whenever it is empty or the next one moves,
// so bubbles close up while the output is stalled. rst_n (synchronous) clears the stage
// valid bits and restores the register reset values.
module relocation_field_patcher (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // input stream
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [4:0]                                   in_tuser,  // [4:0] operation
  input  logic [127:0]                                 in_tdata,  // [63:0] value, [95:64] inst_word,
                                                                  // [127:96] prefix_word
  // result stream
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [3:0]                                   out_tuser, // [0] prefix_written, [3:1] status
  output logic [63:0]                                  out_tdata, // [31:0] inst_out,
                                                                  // [63:32] prefix_out
  // configuration port
  input  logic                                         cfg_psel,
  input  logic                                         cfg_penable,
  input  logic                                         cfg_pwrite,
  input  logic [rfp_pkg::CfgAddrW-1:0]                 cfg_paddr,
  input  logic [rfp_pkg::CfgDataW-1:0]                 cfg_pwdata,
  output logic [rfp_pkg::CfgDataW-1:0]                 cfg_prdata,
  output logic                                         cfg_pready
);

  typedef enum logic [2:0] {
    FK_NONE,
    FK_WORD,
    FK_F9,
    FK_F20,
    FK_F32
  } fkind_t;

  // Stage 1 payload: raw words plus results of the wide arithmetic
  typedef struct packed {
    logic [rfp_pkg::OpW-1:0]   op;
    logic [rfp_pkg::WordW-1:0] inst;
    logic [rfp_pkg::WordW-1:0] pre;
    logic [33:0]               val_lo;   // value[33:0]
    logic                      cog_gt;   // value/4 above cog_abi_max
    logic                      q_le9;    // value/4 fits 9 bits
    logic                      lut_lo;   // value below lut_base
    logic [31:0]               dq;       // (value - lut_base)/4, low bits
    logic                      dq_hi;    // (value - lut_base)/4 at or above 2^20
    logic                      dq_le9;   // (value - lut_base)/4 fits 9 bits
    logic                      neg;      // value negative
    logic [8:0]                mag9;     // (-value)/4, low 9 bits
    logic                      s_fit;    // signed quotient fits the 9-bit field
  } s1_t;

  // Stage 2 payload: field value, field kind and status
  typedef struct packed {
    logic [rfp_pkg::WordW-1:0] inst;
    logic [rfp_pkg::WordW-1:0] pre;
    logic [rfp_pkg::WordW-1:0] fval;
    fkind_t                    kind;
    logic [rfp_pkg::StW-1:0]   st;
  } s2_t;

  logic [rfp_pkg::CfgW-1:0] cog_abi_max_r, lut_base_r, lut_limit_r;
  logic                     cfg_wr;
  logic [1:0]               cfg_idx;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  logic [rfp_pkg::WordW-1:0] inst_out_r, inst_out_nxt, pre_out_r, pre_out_nxt;
  logic                      wrote_r, wrote_nxt;
  logic [rfp_pkg::StW-1:0]   st_r, st_nxt;

  logic [rfp_pkg::ValW-1:0] in_val;
  logic [rfp_pkg::ValW:0]   diff;
  logic [rfp_pkg::ValW-1:0] mag;

  logic [20:0] lut_sum;
  logic        lut_hi;
  logic [8:0]  s_a9;
  logic        fit;

  // ---------------------------------------------------------------------------
  // Configuration registers
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cog_abi_max_r <= rfp_pkg::COG_ABI_MAX_RST;
      lut_base_r    <= rfp_pkg::LUT_BASE_RST;
      lut_limit_r   <= rfp_pkg::LUT_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rfp_pkg::REG_COG_ABI_MAX: cog_abi_max_r <= cfg_pwdata[rfp_pkg::CfgW-1:0];
        rfp_pkg::REG_LUT_BASE:    lut_base_r    <= cfg_pwdata[rfp_pkg::CfgW-1:0];
        rfp_pkg::REG_LUT_LIMIT:   lut_limit_r   <= cfg_pwdata[rfp_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (cfg_idx)
      rfp_pkg::REG_COG_ABI_MAX: cfg_prdata = {12'd0, cog_abi_max_r};
      rfp_pkg::REG_LUT_BASE:    cfg_prdata = {12'd0, lut_base_r};
      rfp_pkg::REG_LUT_LIMIT:   cfg_prdata = {12'd0, lut_limit_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage moves when it is empty or the next one moves
  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: wide subtract, negate and quotient bound flags
  assign in_val = in_tdata[63:0];
  assign diff   = {1'b0, in_val} - {45'd0, lut_base_r};
  assign mag    = ~in_val + 64'd1;

  always_comb begin
    s1_nxt.op     = in_tuser;
    s1_nxt.inst   = in_tdata[95:64];
    s1_nxt.pre    = in_tdata[127:96];
    s1_nxt.val_lo = in_val[33:0];
    s1_nxt.cog_gt = (|in_val[63:22]) || (in_val[21:2] > cog_abi_max_r);
    s1_nxt.q_le9  = ~|in_val[63:11];
    s1_nxt.lut_lo = diff[64];
    s1_nxt.dq     = diff[33:2];
    s1_nxt.dq_hi  = |diff[63:22];
    s1_nxt.dq_le9 = ~|diff[63:11];
    s1_nxt.neg    = in_val[63];
    s1_nxt.mag9   = mag[10:2];
    // negative: |value|/4 <= 256; positive: value/4 <= 255
    if (in_val[63]) begin
      s1_nxt.s_fit = (~|mag[63:11]) && (mag[10:2] <= rfp_pkg::NEG9_MAX);
    end else begin
      s1_nxt.s_fit = ~|in_val[62:10];
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && rdy1) s1_r <= s1_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: rebase, bound checks, field selection
  assign lut_sum = {1'b0, s1_r.dq[19:0]} + {1'b0, lut_base_r};
  assign lut_hi  = s1_r.dq_hi || (lut_sum > {1'b0, lut_limit_r});
  assign s_a9    = s1_r.neg ? (9'd0 - s1_r.mag9) : s1_r.val_lo[10:2];

  always_comb begin
    s2_nxt.inst = s1_r.inst;
    s2_nxt.pre  = s1_r.pre;
    s2_nxt.fval = '0;
    s2_nxt.kind = FK_NONE;
    s2_nxt.st   = rfp_pkg::ST_OK;
    fit         = 1'b1;
    case (s1_r.op)
      rfp_pkg::OP_ABS32: begin
        s2_nxt.fval = s1_r.val_lo[31:0];
        s2_nxt.kind = FK_WORD;
      end
      rfp_pkg::OP_COG_PC20, rfp_pkg::OP_COG_PC9, rfp_pkg::OP_COG_PCAUG32: begin
        if (s1_r.cog_gt) begin
          s2_nxt.st = rfp_pkg::ST_COG;
        end else begin
          s2_nxt.fval = s1_r.val_lo[33:2];
          if (s1_r.op == rfp_pkg::OP_COG_PC20) begin
            s2_nxt.kind = FK_F20;
          end else if (s1_r.op == rfp_pkg::OP_COG_PC9) begin
            s2_nxt.kind = FK_F9;
            fit         = s1_r.q_le9;
          end else begin
            s2_nxt.kind = FK_F32;
          end
        end
      end
      rfp_pkg::OP_COG_DATA9: begin
        s2_nxt.fval = s1_r.val_lo[33:2];
        s2_nxt.kind = FK_F9;
        fit         = s1_r.q_le9;
      end
      rfp_pkg::OP_COG_PCREL9, rfp_pkg::OP_LUT_PCREL9: begin
        s2_nxt.fval = {23'd0, s_a9};
        s2_nxt.kind = FK_F9;
        fit         = s1_r.s_fit;
      end
      rfp_pkg::OP_LUT_PC20, rfp_pkg::OP_LUT_PCAUG32: begin
        if (s1_r.lut_lo) begin
          s2_nxt.st = rfp_pkg::ST_LUTLO;
        end else if (lut_hi) begin
          s2_nxt.st = rfp_pkg::ST_LUTHI;
        end else begin
          // within limit, so the sum fits 20 bits
          s2_nxt.fval = {11'd0, lut_sum};
          s2_nxt.kind = (s1_r.op == rfp_pkg::OP_LUT_PC20) ? FK_F20 : FK_F32;
        end
      end
      rfp_pkg::OP_LUT_PC9, rfp_pkg::OP_LUT_DATA9: begin
        if (s1_r.lut_lo) begin
          s2_nxt.st = rfp_pkg::ST_LUTLO;
        end else begin
          s2_nxt.fval = s1_r.dq;
          s2_nxt.kind = FK_F9;
          fit         = s1_r.dq_le9;
        end
      end
      rfp_pkg::OP_HUB_PC20, rfp_pkg::OP_HUB_PCREL20: begin
        s2_nxt.fval = s1_r.val_lo[31:0];
        s2_nxt.kind = FK_F20;
      end
      rfp_pkg::OP_HUB_PCAUG32, rfp_pkg::OP_HUB_DATAAUG32: begin
        s2_nxt.fval = s1_r.val_lo[31:0];
        s2_nxt.kind = FK_F32;
      end
      rfp_pkg::OP_OBSOLETE: s2_nxt.st = rfp_pkg::ST_OBS;
      default:              s2_nxt.st = rfp_pkg::ST_UNK;
    endcase
    // range error still lets the truncated field through
    if (!fit) s2_nxt.st = rfp_pkg::ST_RANGE;
  end

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) s2_r <= s2_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: merge the field into the words, output register
  always_comb begin
    inst_out_nxt = s2_r.inst;
    pre_out_nxt  = s2_r.pre;
    wrote_nxt    = 1'b0;
    st_nxt       = s2_r.st;
    case (s2_r.kind)
      FK_WORD: inst_out_nxt = s2_r.fval;
      FK_F9:   inst_out_nxt = (s2_r.inst & ~rfp_pkg::MASK9) | (s2_r.fval & rfp_pkg::MASK9);
      FK_F20:  inst_out_nxt = (s2_r.inst & ~rfp_pkg::MASK20) | (s2_r.fval & rfp_pkg::MASK20);
      FK_F32: begin
        inst_out_nxt = (s2_r.inst & ~rfp_pkg::MASK9) | (s2_r.fval & rfp_pkg::MASK9);
        pre_out_nxt  = (s2_r.pre & ~rfp_pkg::MASK23) | ({9'd0, s2_r.fval[31:9]});
        wrote_nxt    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      inst_out_r <= inst_out_nxt;
      pre_out_r  <= pre_out_nxt;
      wrote_r    <= wrote_nxt;
      st_r       <= st_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {pre_out_r, inst_out_r};
  assign out_tuser  = {st_r, wrote_r};

endmodule

[hw/rtl/rfp_checker.sv]
// Port-level checks for the relocation field patcher, bound to the top level.
module rfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [3:0]  out_tuser,
  input logic [63:0] out_tdata
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat shown straight after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  // Prefix rewrite only comes with a clean or range-flagged patch
  a_prefix_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tuser[3:1] == rfp_pkg::ST_OK || out_tuser[3:1] == rfp_pkg::ST_RANGE)
    else $error("prefix rewritten alongside a hard error");

  // With the sink ready, an accepted beat passes stages 1, 2 and 3 in turn and reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("accepted beat did not reach the output in time");

endmodule

bind relocation_field_patcher rfp_checker u_rfp_checker (.*);
